// ===== rtl/scf_pkg.sv =====
// Shared types, constants and state encoding for the strip cluster finder.
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

	localparam int CHANNELS      = 1024;
	localparam int STRIP_IDX_W   = $clog2(CHANNELS);
	localparam int STRIP_CNT_W   = STRIP_IDX_W + 1;
	localparam int SIGNAL_W      = 16;
	localparam int FACTOR_W      = 8;
	localparam int THR_W         = SIGNAL_W + FACTOR_W;
	localparam int SUM_W         = 26;
	localparam int WSUM_W        = 36;
	localparam int COG_W         = 16;
	localparam int COG_FRAC_W    = 6;
	localparam int DIVIDEND_W    = WSUM_W + COG_FRAC_W;
	localparam int DIV_STEPS     = COG_W;
	localparam int DIV_STEP_W    = $clog2(DIV_STEPS);
	localparam int CFG_INDEX_W   = 8;

	localparam logic [THR_W-1:0]    THR_ONE              = THR_W'(256);
	localparam logic [FACTOR_W-1:0] SEED_FACTOR_RST      = FACTOR_W'(80);
	localparam logic [FACTOR_W-1:0] NEIGHBOUR_FACTOR_RST = FACTOR_W'(32);

	localparam logic [CFG_INDEX_W-1:0] REG_SEED_FACTOR      = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_NEIGHBOUR_FACTOR = CFG_INDEX_W'(1);

	typedef struct packed {
		logic signed [SIGNAL_W-1:0] strip_signal;
		logic [SIGNAL_W-1:0]        strip_sigma;
		logic                       strip_masked;
		logic signed [SIGNAL_W-1:0] chip_common_noise;
	} strip_t;

	typedef struct packed {
		logic [STRIP_IDX_W-1:0]     start_strip;
		logic [STRIP_CNT_W-1:0]     strip_count;
		logic [COG_W-1:0]           centroid;
		logic signed [SIGNAL_W-1:0] cluster_common_noise;
	} cluster_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_PREP,
		ST_DIV,
		ST_LOAD
	} scf_state_t;

	typedef struct packed {
		logic load_strip;
		logic eval;
		logic prep;
		logic div_step;
		logic load_out;
	} scf_cmd_t;

	typedef struct packed {
		logic emit;
	} scf_status_t;

endpackage

`default_nettype wire

// ===== rtl/strip_cluster_finder_core.sv =====
// Top level of the strip cluster finder: controller, datapath and configuration port.
//
// Strips of one event enter on the strip channel, one transaction per strip, in
// order; the strip index is counted inside and wraps after CHANNELS strips.
// Clusters leave on the cluster channel, at most one per strip transaction.
// Configuration writes (seed_factor at index 0, neighbour_factor at index 1)
// are taken on the cfg channel in any cycle; issue them while the block is idle.
// A strip that closes no cluster is accepted, then evaluated.
// A strip that closes a cluster is accepted and evaluated, then passes divider
// setup, 16 steps of the restoring divider for the center of gravity, and the
// load of the output register. The cluster is valid on the cycle after the load.
// The divider, one quotient bit per cycle, sets the per-cluster cost.
// While a cluster waits in the output register, strips are still accepted;
// a second cluster waits after its division until the register is free, and
// no strip is accepted meanwhile.
// Reset clears the strip counter and the open run, drops any pending cluster
// and restores the factors to 5.0 and 2.0.
`timescale 1ns / 1ps
`default_nettype none

module strip_cluster_finder_core
	import scf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   strip_valid,
	output logic                        strip_ready,
	input  wire strip_t                 strip,
	output logic                        cluster_valid,
	input  wire logic                   cluster_ready,
	output cluster_t                    cluster,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [FACTOR_W-1:0]    cfg_data
);

	scf_cmd_t    cmd;
	scf_status_t status;

	assign cfg_ready = 1'b1;

	scf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.strip_valid   (strip_valid),
		.strip_ready   (strip_ready),
		.cluster_valid (cluster_valid),
		.cluster_ready (cluster_ready),
		.status        (status),
		.cmd           (cmd)
	);

	scf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.strip     (strip),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.cluster   (cluster)
	);

endmodule

`default_nettype wire

// ===== rtl/scf_ctrl.sv =====
// Controller state machine: strip intake, evaluation, division sequencing, output handoff.
`timescale 1ns / 1ps
`default_nettype none

module scf_ctrl
	import scf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        strip_valid,
	output logic             strip_ready,
	output logic             cluster_valid,
	input  wire logic        cluster_ready,
	input  wire scf_status_t status,
	output scf_cmd_t         cmd
);

	scf_state_t state_q, state_d;
	logic [DIV_STEP_W-1:0] step_q;
	logic cluster_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		strip_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				strip_ready = 1'b1;
				if (strip_valid) begin
					cmd.load_strip = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d = status.emit ? ST_PREP : ST_IDLE;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == DIV_STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (!cluster_valid_q || cluster_ready) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.prep) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			cluster_valid_q <= 1'b1;
		end else if (cluster_ready) begin
			cluster_valid_q <= 1'b0;
		end
	end

	assign cluster_valid = cluster_valid_q;

endmodule

`default_nettype wire

// ===== rtl/scf_datapath.sv =====
// Datapath: thresholds, run accumulation, restoring divider and output register.
`timescale 1ns / 1ps
`default_nettype none

module scf_datapath
	import scf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire strip_t                 strip,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [FACTOR_W-1:0]    cfg_data,
	input  wire scf_cmd_t               cmd,
	output scf_status_t                 status,
	output cluster_t                    cluster
);

	logic [FACTOR_W-1:0] seed_factor_q, neighbour_factor_q;

	strip_t strip_q;

	logic [STRIP_IDX_W-1:0] strip_counter_q;
	logic                   run_active_q;
	logic [STRIP_IDX_W-1:0] run_start_q;
	logic [STRIP_IDX_W-1:0] run_end_q;
	logic                   seed_seen_q;
	logic [SUM_W-1:0]       signal_total_q;
	logic [WSUM_W-1:0]      weighted_total_q;

	logic [STRIP_IDX_W-1:0] cap_first_q;
	logic [STRIP_CNT_W-1:0] cap_count_q;
	logic [SIGNAL_W-1:0]    cap_noise_q;
	logic [SUM_W-1:0]       cap_sum_q;
	logic [WSUM_W-1:0]      cap_wsum_q;

	logic [SUM_W-1:0]       rem_q;
	logic [COG_W-1:0]       low_q;
	logic [COG_W-1:0]       quo_q;
	logic                   ovf_q;
	logic                   zero_q;

	cluster_t cluster_q;

	logic                   sig_pos;
	logic [THR_W-1:0]       sig8;
	logic [THR_W-1:0]       seed_prod, nb_prod, seed_thr, nb_thr;
	logic                   include_strip, seed_hit, last_strip;
	logic [SUM_W-2:0]       weight_prod;
	logic [SUM_W-1:0]       sum_next;
	logic [WSUM_W-1:0]      wsum_next;
	logic [STRIP_IDX_W-1:0] sel_first, sel_end;
	logic                   emit;
	logic [DIVIDEND_W-1:0]  dividend;
	logic [SUM_W:0]         rem_shift, rem_diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_factor_q      <= SEED_FACTOR_RST;
			neighbour_factor_q <= NEIGHBOUR_FACTOR_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SEED_FACTOR:      seed_factor_q <= cfg_data;
				REG_NEIGHBOUR_FACTOR: neighbour_factor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_strip) begin
			strip_q <= strip;
		end
	end

	always_comb begin
		sig_pos   = !strip_q.strip_signal[SIGNAL_W-1];
		sig8      = {5'b0, strip_q.strip_signal[SIGNAL_W-2:0], 4'b0};
		seed_prod = THR_W'(strip_q.strip_sigma) * THR_W'(seed_factor_q);
		nb_prod   = THR_W'(strip_q.strip_sigma) * THR_W'(neighbour_factor_q);
		seed_thr  = (seed_prod == '0) ? THR_ONE : seed_prod;
		nb_thr    = (nb_prod == '0) ? THR_ONE : nb_prod;

		include_strip = !strip_q.strip_masked && sig_pos && (sig8 >= nb_thr);
		seed_hit      = sig_pos && (sig8 >= seed_thr);
		last_strip    = (strip_counter_q == STRIP_IDX_W'(CHANNELS - 1));

		weight_prod = (SUM_W-1)'(strip_q.strip_signal[SIGNAL_W-2:0])
			* (SUM_W-1)'(strip_counter_q);
		sum_next    = signal_total_q + SUM_W'(strip_q.strip_signal[SIGNAL_W-2:0]);
		wsum_next   = weighted_total_q + WSUM_W'(weight_prod);

		if (include_strip) begin
			sel_first = run_active_q ? run_start_q : strip_counter_q;
			sel_end   = strip_counter_q;
			emit      = last_strip && (seed_seen_q || seed_hit);
		end else begin
			sel_first = run_start_q;
			sel_end   = run_end_q;
			emit      = run_active_q && seed_seen_q;
		end
		status.emit = emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_counter_q  <= '0;
			run_active_q     <= 1'b0;
			run_start_q      <= '0;
			run_end_q        <= '0;
			seed_seen_q      <= 1'b0;
			signal_total_q   <= '0;
			weighted_total_q <= '0;
		end else if (cmd.eval) begin
			strip_counter_q <= last_strip ? '0 : strip_counter_q + 1'b1;
			if (include_strip && !last_strip) begin
				run_active_q     <= 1'b1;
				run_start_q      <= sel_first;
				run_end_q        <= strip_counter_q;
				seed_seen_q      <= seed_seen_q || seed_hit;
				signal_total_q   <= sum_next;
				weighted_total_q <= wsum_next;
			end else begin
				run_active_q     <= 1'b0;
				run_start_q      <= '0;
				run_end_q        <= '0;
				seed_seen_q      <= 1'b0;
				signal_total_q   <= '0;
				weighted_total_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval && emit) begin
			cap_first_q <= sel_first;
			cap_count_q <= STRIP_CNT_W'(sel_end - sel_first) + 1'b1;
			cap_noise_q <= strip_q.chip_common_noise;
			cap_sum_q   <= include_strip ? sum_next : signal_total_q;
			cap_wsum_q  <= include_strip ? wsum_next : weighted_total_q;
		end
	end

	assign dividend  = {cap_wsum_q, {COG_FRAC_W{1'b0}}}
		+ DIVIDEND_W'(cap_sum_q[SUM_W-1:1]);
	assign rem_shift = {rem_q, low_q[COG_W-1]};
	assign rem_diff  = rem_shift - {1'b0, cap_sum_q};

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rem_q  <= dividend[DIVIDEND_W-1:COG_W];
			low_q  <= dividend[COG_W-1:0];
			quo_q  <= '0;
			ovf_q  <= (dividend[DIVIDEND_W-1:COG_W] >= cap_sum_q);
			zero_q <= (cap_sum_q == '0);
		end else if (cmd.div_step) begin
			low_q <= {low_q[COG_W-2:0], 1'b0};
			if (!rem_diff[SUM_W]) begin
				rem_q <= rem_diff[SUM_W-1:0];
				quo_q <= {quo_q[COG_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[SUM_W-1:0];
				quo_q <= {quo_q[COG_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cluster_q.start_strip          <= cap_first_q;
			cluster_q.strip_count          <= cap_count_q;
			cluster_q.cluster_common_noise <= cap_noise_q;
			priority if (zero_q) begin
				cluster_q.centroid <= '0;
			end else if (ovf_q) begin
				cluster_q.centroid <= '1;
			end else begin
				cluster_q.centroid <= quo_q;
			end
		end
	end

	assign cluster = cluster_q;

endmodule

`default_nettype wire

// ===== dv/strip_cluster_finder_core_test.sv =====
// Self-checking testbench for the strip cluster finder core with its own cluster predictor.
`timescale 1ns / 1ps

module strip_cluster_finder_core_test;
	import scf_pkg::*;

	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum {
		LVL_QUIET,
		LVL_NEIGHBOUR,
		LVL_SEED,
		LVL_MASKED,
		LVL_WILD
	} strip_kind_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   strip_valid = 1'b0;
	logic                   strip_ready;
	strip_t                 strip = '0;
	logic                   cluster_valid;
	logic                   cluster_ready = 1'b0;
	cluster_t               cluster;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [FACTOR_W-1:0]    cfg_data = '0;

	// predictor state and register copies
	logic [FACTOR_W-1:0]    seed_factor_q = SEED_FACTOR_RST;
	logic [FACTOR_W-1:0]    neighbour_factor_q = NEIGHBOUR_FACTOR_RST;
	logic [STRIP_IDX_W-1:0] strip_idx = '0;
	bit                     run_open = 1'b0;
	logic [STRIP_IDX_W-1:0] run_first = '0;
	logic [STRIP_IDX_W-1:0] run_last = '0;
	bit                     run_seeded = 1'b0;
	logic [SUM_W-1:0]       sig_sum = '0;
	logic [WSUM_W-1:0]      wsig_sum = '0;

	cluster_t pending_clusters[$];
	cluster_t expected_cluster;
	int       mismatch_count = 0;
	int       items_sent = 0;
	int       event_ends = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       hold_req_seq = 0;
	int       hold_seen_seq = 0;
	int       hold_left = 0;
	int       quiet_cycles = 0;

	strip_cluster_finder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.strip_valid   (strip_valid),
		.strip_ready   (strip_ready),
		.strip         (strip),
		.cluster_valid (cluster_valid),
		.cluster_ready (cluster_ready),
		.cluster       (cluster),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic bit close_run(input logic signed [SIGNAL_W-1:0] noise,
			output cluster_t c);
		longint unsigned num, den, quo;
		bit hit;
		hit = run_open && run_seeded;
		c = '0;
		if (hit) begin
			den = 64'(sig_sum);
			quo = 0;
			if (den != 0) begin
				num = (64'(wsig_sum) << COG_FRAC_W) + (den >> 1);
				quo = num / den;
				if (quo > 64'hFFFF)
					quo = 64'hFFFF;
			end
			c.start_strip = run_first;
			c.strip_count = STRIP_CNT_W'(run_last) - STRIP_CNT_W'(run_first) + 1'b1;
			c.centroid = COG_W'(quo);
			c.cluster_common_noise = noise;
		end
		run_open = 1'b0;
		run_first = '0;
		run_last = '0;
		run_seeded = 1'b0;
		sig_sum = '0;
		wsig_sum = '0;
		return hit;
	endfunction

	function automatic bit predict_cluster(input strip_t s, output cluster_t c);
		logic [THR_W-1:0] seed_thr, nb_thr;
		int sig_q8;
		bit emitted;
		seed_thr = s.strip_sigma * seed_factor_q;
		nb_thr = s.strip_sigma * neighbour_factor_q;
		if (seed_thr == 0)
			seed_thr = THR_ONE;
		if (nb_thr == 0)
			nb_thr = THR_ONE;
		sig_q8 = int'(s.strip_signal) * 16;
		emitted = 1'b0;
		c = '0;
		if (!s.strip_masked && sig_q8 >= int'(nb_thr)) begin
			if (sig_q8 >= int'(seed_thr))
				run_seeded = 1'b1;
			if (!run_open) begin
				run_open = 1'b1;
				run_first = strip_idx;
			end
			run_last = strip_idx;
			sig_sum += SUM_W'(s.strip_signal);
			wsig_sum += WSUM_W'(s.strip_signal) * WSUM_W'(strip_idx);
		end else begin
			emitted = close_run(s.chip_common_noise, c);
		end
		if (int'(strip_idx) == CHANNELS - 1) begin
			if (!emitted)
				emitted = close_run(s.chip_common_noise, c);
			strip_idx = '0;
		end else begin
			strip_idx++;
		end
		return emitted;
	endfunction

	function automatic int signal_floor(input logic [FACTOR_W-1:0] factor,
			input logic [SIGNAL_W-1:0] sigma);
		int thr;
		thr = int'(sigma) * int'(factor);
		if (thr == 0)
			thr = 256;
		return (thr + 15) / 16;
	endfunction

	function automatic strip_t strip_of(input int sig, input int sigma, input bit masked,
			input int noise);
		strip_t s;
		s.strip_signal = SIGNAL_W'(sig);
		s.strip_sigma = SIGNAL_W'(sigma);
		s.strip_masked = masked;
		s.chip_common_noise = SIGNAL_W'(noise);
		return s;
	endfunction

	function automatic strip_t make_strip(input strip_kind_t kind);
		strip_t s;
		int nb_sig, seed_sig, lo, hi, v;
		s.strip_sigma = ($urandom_range(9) == 0) ? '0 : SIGNAL_W'($urandom_range(48));
		s.strip_masked = 1'b0;
		s.chip_common_noise = SIGNAL_W'($urandom);
		nb_sig = signal_floor(neighbour_factor_q, s.strip_sigma);
		seed_sig = signal_floor(seed_factor_q, s.strip_sigma);
		case (kind)
			LVL_QUIET: begin
				hi = (nb_sig - 1 > 32767) ? 32767 : nb_sig - 1;
				if ($urandom_range(3) == 0)
					v = -int'($urandom_range(32768));
				else
					v = $urandom_range(hi);
			end
			LVL_NEIGHBOUR: begin
				lo = nb_sig;
				hi = (seed_sig - 1 < lo) ? lo : seed_sig - 1;
				if (hi > 32767)
					hi = 32767;
				if (lo > hi)
					lo = hi;
				v = $urandom_range(hi, lo);
			end
			LVL_SEED: begin
				lo = (seed_sig > nb_sig) ? seed_sig : nb_sig;
				v = lo + $urandom_range(40);
			end
			LVL_MASKED: begin
				s.strip_masked = 1'b1;
				v = int'(SIGNAL_W'($urandom)) - 32768;
			end
			default: begin
				s.strip_sigma = SIGNAL_W'($urandom);
				s.strip_masked = 1'($urandom_range(1));
				v = int'(SIGNAL_W'($urandom)) - 32768;
			end
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		s.strip_signal = SIGNAL_W'(v);
		return s;
	endfunction

	task automatic send_strip(input strip_t s);
		cluster_t c;
		while ($urandom_range(99) < send_idle_pct) begin
			strip_valid <= 1'b0;
			@(posedge clk);
		end
		strip_valid <= 1'b1;
		strip <= s;
		@(posedge clk);
		while (!strip_ready)
			@(posedge clk);
		if (predict_cluster(s, c))
			pending_clusters.push_back(c);
		items_sent++;
	endtask

	task automatic send_run(input int len, input bit seeded);
		int seed_at;
		seed_at = $urandom_range(len - 1);
		for (int i = 0; i < len; i++) begin
			if (seeded && (i == seed_at || $urandom_range(3) == 0))
				send_strip(make_strip(LVL_SEED));
			else
				send_strip(make_strip(LVL_NEIGHBOUR));
		end
	endtask

	task automatic send_closer();
		if ($urandom_range(1))
			send_strip(make_strip(LVL_QUIET));
		else
			send_strip(make_strip(LVL_MASKED));
	endtask

	task automatic wait_idle();
		strip_valid <= 1'b0;
		while (pending_clusters.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic config_factors(input logic [FACTOR_W-1:0] seed_f,
			input logic [FACTOR_W-1:0] nb_f);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_SEED_FACTOR;
		cfg_data <= seed_f;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		seed_factor_q = seed_f;
		cfg_index <= REG_NEIGHBOUR_FACTOR;
		cfg_data <= nb_f;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		neighbour_factor_q = nb_f;
		cfg_valid <= 1'b0;
	endtask

	// alternate a run through the last strip with a run closed by the last strip
	task automatic finish_event();
		while (int'(strip_idx) != CHANNELS - 5)
			send_strip(make_strip(LVL_QUIET));
		if (event_ends % 2 == 0) begin
			send_run(5, 1'b1);
		end else begin
			send_run(4, 1'b1);
			send_strip(make_strip(LVL_QUIET));
		end
		event_ends++;
	endtask

	task automatic random_strips(input int n);
		int target, r;
		target = items_sent + n;
		while (items_sent < target) begin
			if (int'(strip_idx) >= CHANNELS - 34) begin
				finish_event();
			end else begin
				r = $urandom_range(99);
				if (r < 60) begin
					send_run(($urandom_range(9) == 0) ? $urandom_range(28, 7)
						: $urandom_range(5, 1), 1'b1);
					send_closer();
				end else if (r < 75) begin
					send_strip(make_strip(LVL_QUIET));
				end else if (r < 88) begin
					send_strip(make_strip(LVL_WILD));
				end else if (r < 94) begin
					send_run($urandom_range(4, 1), 1'b0);
					send_strip(make_strip(LVL_QUIET));
				end else begin
					send_run($urandom_range(3, 1), 1'b1);
					send_strip(make_strip(LVL_MASKED));
					send_run($urandom_range(3, 1), 1'b1);
					send_closer();
				end
			end
		end
	endtask

	task automatic test_thresholds();
		send_strip(strip_of(32767, 0, 1'b0, -32768));
		send_strip(strip_of(40, 16, 1'b0, 1));
		send_strip(strip_of(32767, 16, 1'b1, 32767));
		send_strip(strip_of(40, 16, 1'b0, 0));
		send_strip(strip_of(50, 16, 1'b0, 0));
		send_strip(strip_of(-32768, 0, 1'b0, 0));
		send_strip(strip_of(32, 16, 1'b0, 0));
		send_strip(strip_of(80, 16, 1'b0, 0));
		send_strip(strip_of(31, 16, 1'b0, -1));
		send_strip(strip_of(32767, 65535, 1'b0, 0));
		send_strip(strip_of(16, 0, 1'b0, 0));
		send_strip(strip_of(15, 0, 1'b0, 0));
		send_strip(strip_of(5, 3, 1'b1, 0));
		send_strip(strip_of(0, 0, 1'b0, 0));
	endtask

	task automatic test_factor_extremes();
		config_factors(8'd0, 8'd0);
		send_strip(strip_of(16, 65535, 1'b0, 100));
		send_strip(strip_of(20, 1234, 1'b0, -5));
		send_strip(strip_of(-1, 0, 1'b0, 7));
		config_factors(8'd255, 8'd255);
		send_strip(strip_of(16, 1, 1'b0, 1));
		send_strip(strip_of(15, 1, 1'b0, 2));
		config_factors(8'd16, 8'd255);
		send_strip(strip_of(20, 16, 1'b0, 3));
		send_strip(strip_of(255, 16, 1'b0, 4));
		send_strip(strip_of(254, 16, 1'b0, 5));
	endtask

	task automatic test_random_traffic();
		config_factors(SEED_FACTOR_RST, NEIGHBOUR_FACTOR_RST);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_strips(350);
		config_factors(8'd40, 8'd24);
		send_idle_pct = 76;
		recv_stall_pct = 0;
		random_strips(350);
		config_factors(8'd255, 8'd0);
		send_idle_pct = 0;
		recv_stall_pct = 76;
		random_strips(350);
		config_factors(8'd96, 8'd48);
		send_idle_pct = 20;
		recv_stall_pct = 20;
		random_strips(350);
	endtask

	task automatic test_backpressure();
		wait_idle();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req_seq <= hold_req_seq + 1;
		repeat (30) begin
			send_run(1, 1'b1);
			send_closer();
		end
		wait_idle();
	endtask

	task automatic test_event_end();
		send_idle_pct = 20;
		recv_stall_pct = 20;
		while (event_ends < 2)
			random_strips(1);
	endtask

	task automatic check_field(input string field, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		if (hold_req_seq != hold_seen_seq) begin
			hold_seen_seq = hold_req_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			cluster_ready <= 1'b0;
		end else begin
			cluster_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && cluster_valid && cluster_ready) begin
			if (pending_clusters.size() == 0) begin
				$display("%0t: cluster transaction with none expected, actual start %0d width %0d",
					$time, cluster.start_strip, cluster.strip_count);
				mismatch_count++;
			end else begin
				expected_cluster = pending_clusters.pop_front();
				check_field("start_strip", expected_cluster.start_strip, cluster.start_strip);
				check_field("strip_count", expected_cluster.strip_count, cluster.strip_count);
				check_field("centroid", expected_cluster.centroid, cluster.centroid);
				check_field("cluster_common_noise", expected_cluster.cluster_common_noise,
					cluster.cluster_common_noise);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((strip_valid && strip_ready) || (cluster_valid && cluster_ready)
					|| (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("CHECK FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_thresholds();
		test_factor_extremes();
		test_random_traffic();
		test_backpressure();
		test_event_end();
		wait_idle();
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
